// File: hdl/hrt_pkg.sv
// ----------------------------------------------------------------------------
// hrt_pkg: shared definitions of the HTTP request header tokenizer
// Token kinds, error codes, parse phases, limits and the packed records that
// travel from the front end through the queue to the result serializer.
// ----------------------------------------------------------------------------
package hrt_pkg;

  localparam int MAX_FIELDS  = 32;
  localparam int OFFSET_BITS = 16;
  localparam int FIELDS_BITS = $clog2(MAX_FIELDS + 1);
  localparam int QDEPTH      = 4;
  localparam int QPTR_BITS   = $clog2(QDEPTH);
  localparam int RUN_MAX     = 3;

  // Token kinds.
  localparam logic [2:0] K_METHOD = 3'd0;
  localparam logic [2:0] K_URI    = 3'd1;
  localparam logic [2:0] K_VER    = 3'd2;
  localparam logic [2:0] K_DEFVER = 3'd3;
  localparam logic [2:0] K_NAME   = 3'd4;
  localparam logic [2:0] K_VALUE  = 3'd5;
  localparam logic [2:0] K_DONE   = 3'd6;
  localparam logic [2:0] K_ERROR  = 3'd7;

  // Error codes.
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_REQ_LINE  = 3'd1;
  localparam logic [2:0] ERR_FIELD     = 3'd2;
  localparam logic [2:0] ERR_TOO_MANY  = 3'd3;
  localparam logic [2:0] ERR_TRUNCATED = 3'd4;

  // Parse phases.
  localparam logic [3:0] PH_METHOD     = 4'd0;
  localparam logic [3:0] PH_URI_SKIP   = 4'd1;
  localparam logic [3:0] PH_URI        = 4'd2;
  localparam logic [3:0] PH_VER_SKIP   = 4'd3;
  localparam logic [3:0] PH_VER        = 4'd4;
  localparam logic [3:0] PH_VER_TAIL   = 4'd5;
  localparam logic [3:0] PH_RL_LF      = 4'd6;
  localparam logic [3:0] PH_NAME_START = 4'd7;
  localparam logic [3:0] PH_NAME       = 4'd8;
  localparam logic [3:0] PH_VAL_SKIP   = 4'd9;
  localparam logic [3:0] PH_VAL        = 4'd10;
  localparam logic [3:0] PH_VAL_LF     = 4'd11;
  localparam logic [3:0] PH_BLANK_LF   = 4'd12;
  localparam logic [3:0] PH_HALT       = 4'd13;

  // Characters.
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_HT    = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_COLON = 8'h3A;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] start;
    logic [15:0] length;
    logic [4:0]  fidx;
    logic [2:0]  err;
  } res_t;

  // All results caused by one byte, in order; cnt is 1 to RUN_MAX.
  typedef struct packed {
    logic [1:0]              cnt;
    res_t [RUN_MAX-1:0]      slot;
  } run_t;

  // Queue status seen by the two sides.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// File: hdl/hrt_if.sv
// ----------------------------------------------------------------------------
// hrt_if: valid/ready channels of the HTTP request header tokenizer
// One interface for header bytes and one for token results.
// ----------------------------------------------------------------------------
interface hrt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_buffer;

  modport source (output valid, output data_byte, output end_of_buffer, input ready);
  modport sink   (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

interface hrt_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  token_kind;
  logic [15:0] token_start;
  logic [15:0] token_length;
  logic [4:0]  field_index;
  logic [2:0]  error_code;
  logic        last_of_run;

  modport source (output valid, output token_kind, output token_start,
                  output token_length, output field_index, output error_code,
                  output last_of_run, input ready);
  modport sink   (input valid, input token_kind, input token_start,
                  input token_length, input field_index, input error_code,
                  input last_of_run, output ready);
endinterface

// File: hdl/hrt_front.sv
// ----------------------------------------------------------------------------
// hrt_front: byte classifier and parse state machine
// Takes one header byte per transfer, advances the parse phase and builds
// the run of results that the byte causes.
// ----------------------------------------------------------------------------
module hrt_front (
  input  logic             clk,
  input  logic             rst_n,
  hrt_in_if.sink           in_ch,
  input  hrt_pkg::q_stat_t q_stat,
  output logic             push,
  output hrt_pkg::run_t    push_run
);
  import hrt_pkg::*;

  logic [3:0]             phase_r, phase_nxt;
  logic [OFFSET_BITS-1:0] off_r, off_nxt;
  logic [OFFSET_BITS-1:0] cts_r, cts_nxt;
  logic [FIELDS_BITS-1:0] fs_r, fs_nxt;

  logic [OFFSET_BITS-1:0] len0, len1;
  logic [7:0]             c;
  logic                   eob, blank, rlws, halted, fin, xfer;
  logic [4:0]             fidx;
  run_t                   run;

  function automatic res_t mk(input logic [2:0] kind, input logic [OFFSET_BITS-1:0] start,
                              input logic [OFFSET_BITS-1:0] len, input logic [4:0] fi,
                              input logic [2:0] err);
    res_t r;
    r.kind   = kind;
    r.start  = 16'(start);
    r.length = 16'(len);
    r.fidx   = fi;
    r.err    = err;
    return r;
  endfunction

  function automatic run_t add(input run_t r, input res_t x);
    run_t o;
    o = r;
    o.slot[r.cnt] = x;
    o.cnt = r.cnt + 2'd1;
    return o;
  endfunction

  assign c      = in_ch.data_byte;
  assign eob    = in_ch.end_of_buffer;
  assign blank  = (c == CH_SP) || (c == CH_HT) || (c == CH_VT) || (c == CH_FF);
  assign rlws   = blank || (c == CH_LF);
  assign halted = (phase_r == PH_HALT);
  assign len0   = off_r - cts_r;
  assign len1   = off_r + 1'b1 - cts_r;
  assign fidx   = fs_r[4:0];
  assign xfer   = in_ch.valid && in_ch.ready;

  assign in_ch.ready = !q_stat.full;

  always_comb begin
    phase_nxt = phase_r;
    off_nxt   = off_r;
    cts_nxt   = cts_r;
    fs_nxt    = fs_r;
    run       = '0;
    fin       = 1'b0;

    case (phase_r)
      PH_METHOD: begin
        if (c == CH_CR) begin
          run = add(run, mk(K_ERROR, off_r, '0, '0, ERR_REQ_LINE));
          fin = 1'b1;
          phase_nxt = PH_HALT;
        end else if (rlws) begin
          run = add(run, mk(K_METHOD, cts_r, len0, '0, ERR_NONE));
          phase_nxt = PH_URI_SKIP;
        end else if (eob) begin
          run = add(run, mk(K_ERROR, off_r, '0, '0, ERR_REQ_LINE));
          fin = 1'b1;
          phase_nxt = PH_HALT;
        end
      end
      PH_URI_SKIP: begin
        if (c == CH_CR) begin
          run = add(run, mk(K_URI, off_r, '0, '0, ERR_NONE));
          run = add(run, mk(K_DEFVER, off_r, '0, '0, ERR_NONE));
          phase_nxt = PH_RL_LF;
        end else if (!rlws) begin
          cts_nxt = off_r;
          phase_nxt = PH_URI;
          if (eob) run = add(run, mk(K_URI, off_r, OFFSET_BITS'(1), '0, ERR_NONE));
        end
      end
      PH_URI: begin
        if (c == CH_CR) begin
          run = add(run, mk(K_URI, cts_r, len0, '0, ERR_NONE));
          run = add(run, mk(K_DEFVER, off_r, '0, '0, ERR_NONE));
          phase_nxt = PH_RL_LF;
        end else if (rlws) begin
          run = add(run, mk(K_URI, cts_r, len0, '0, ERR_NONE));
          phase_nxt = PH_VER_SKIP;
        end else if (eob) begin
          run = add(run, mk(K_URI, cts_r, len1, '0, ERR_NONE));
        end
      end
      PH_VER_SKIP: begin
        if (c == CH_CR) begin
          run = add(run, mk(K_VER, off_r, '0, '0, ERR_NONE));
          phase_nxt = PH_RL_LF;
        end else if (!rlws) begin
          cts_nxt = off_r;
          phase_nxt = PH_VER;
          if (eob) run = add(run, mk(K_VER, off_r, OFFSET_BITS'(1), '0, ERR_NONE));
        end
      end
      PH_VER: begin
        if (c == CH_CR) begin
          run = add(run, mk(K_VER, cts_r, len0, '0, ERR_NONE));
          phase_nxt = PH_RL_LF;
        end else if (rlws) begin
          run = add(run, mk(K_VER, cts_r, len0, '0, ERR_NONE));
          phase_nxt = PH_VER_TAIL;
        end else if (eob) begin
          run = add(run, mk(K_VER, cts_r, len1, '0, ERR_NONE));
        end
      end
      PH_VER_TAIL: begin
        if (c == CH_CR) begin
          phase_nxt = PH_RL_LF;
        end else if (!rlws) begin
          run = add(run, mk(K_ERROR, off_r, '0, '0, ERR_REQ_LINE));
          fin = 1'b1;
          phase_nxt = PH_HALT;
        end
      end
      PH_RL_LF, PH_VAL_LF: begin
        if (c != CH_LF) begin
          run = add(run, mk(K_ERROR, off_r, '0, '0,
                            (phase_r == PH_RL_LF) ? ERR_REQ_LINE : ERR_FIELD));
          fin = 1'b1;
          phase_nxt = PH_HALT;
        end else if (eob) begin
          run = add(run, mk(K_DONE, off_r, '0, '0, ERR_NONE));
          fin = 1'b1;
          phase_nxt = PH_HALT;
        end else begin
          phase_nxt = PH_NAME_START;
        end
      end
      PH_NAME_START: begin
        if (c == CH_CR) begin
          phase_nxt = PH_BLANK_LF;
        end else if (fs_r >= FIELDS_BITS'(MAX_FIELDS)) begin
          run = add(run, mk(K_ERROR, off_r, '0, '0, ERR_TOO_MANY));
          fin = 1'b1;
          phase_nxt = PH_HALT;
        end else begin
          cts_nxt = off_r;
          if (c == CH_COLON) begin
            run = add(run, mk(K_NAME, off_r, '0, fidx, ERR_NONE));
            phase_nxt = PH_VAL_SKIP;
          end else if (c == CH_LF) begin
            run = add(run, mk(K_ERROR, off_r, '0, '0, ERR_FIELD));
            fin = 1'b1;
            phase_nxt = PH_HALT;
          end else begin
            phase_nxt = PH_NAME;
          end
        end
      end
      PH_NAME: begin
        if (c == CH_COLON) begin
          run = add(run, mk(K_NAME, cts_r, len0, fidx, ERR_NONE));
          phase_nxt = PH_VAL_SKIP;
        end else if (c == CH_CR || c == CH_LF) begin
          run = add(run, mk(K_ERROR, off_r, '0, '0, ERR_FIELD));
          fin = 1'b1;
          phase_nxt = PH_HALT;
        end
      end
      PH_VAL_SKIP: begin
        if (c == CH_CR || c == CH_LF) begin
          run = add(run, mk(K_ERROR, off_r, '0, '0, ERR_FIELD));
          fin = 1'b1;
          phase_nxt = PH_HALT;
        end else if (!blank) begin
          cts_nxt = off_r;
          phase_nxt = PH_VAL;
          if (eob) run = add(run, mk(K_VALUE, off_r, OFFSET_BITS'(1), fidx, ERR_NONE));
        end
      end
      PH_VAL: begin
        if (c == CH_CR) begin
          run = add(run, mk(K_VALUE, cts_r, len0, fidx, ERR_NONE));
          fs_nxt = fs_r + 1'b1;
          phase_nxt = PH_VAL_LF;
        end else if (eob) begin
          run = add(run, mk(K_VALUE, cts_r, len1, fidx, ERR_NONE));
        end
      end
      PH_BLANK_LF: begin
        if (c == CH_LF) run = add(run, mk(K_DONE, off_r, '0, '0, ERR_NONE));
        else            run = add(run, mk(K_ERROR, off_r, '0, '0, ERR_FIELD));
        fin = 1'b1;
        phase_nxt = PH_HALT;
      end
      default: begin
        phase_nxt = PH_HALT;
      end
    endcase

    if (eob && !halted && !fin) begin
      run = add(run, mk(K_ERROR, off_r, '0, '0, ERR_TRUNCATED));
      phase_nxt = PH_HALT;
    end
    if (!halted) off_nxt = off_r + 1'b1;
    if (eob) begin
      phase_nxt = PH_METHOD;
      off_nxt   = '0;
      cts_nxt   = '0;
      fs_nxt    = '0;
    end
  end

  assign push     = xfer && (run.cnt != 2'd0);
  assign push_run = run;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_METHOD;
      off_r   <= '0;
      cts_r   <= '0;
      fs_r    <= '0;
    end else if (xfer) begin
      phase_r <= phase_nxt;
      off_r   <= off_nxt;
      cts_r   <= cts_nxt;
      fs_r    <= fs_nxt;
    end
  end

endmodule

// File: hdl/hrt_queue.sv
// ----------------------------------------------------------------------------
// hrt_queue: short queue of result runs
// Decouples the parse front end from the result serializer.
// ----------------------------------------------------------------------------
module hrt_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  hrt_pkg::run_t    push_run,
  input  logic             pop,
  output hrt_pkg::run_t    head_run,
  output hrt_pkg::q_stat_t q_stat
);
  import hrt_pkg::*;

  run_t                 q_mem [QDEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_BITS:0]   cnt_r;
  logic                 do_push, do_pop;

  assign q_stat.full  = (cnt_r == (QPTR_BITS+1)'(QDEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head_run     = q_mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) q_mem[wr_ptr_r] <= push_run;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// File: hdl/hrt_back.sv
// ----------------------------------------------------------------------------
// hrt_back: result serializer
// Holds one run in an output register and hands its results out one per
// transfer, marking the last one of the run.
// ----------------------------------------------------------------------------
module hrt_back (
  input  logic             clk,
  input  logic             rst_n,
  input  hrt_pkg::run_t    head_run,
  input  hrt_pkg::q_stat_t q_stat,
  output logic             pop,
  hrt_out_if.source        out_ch
);
  import hrt_pkg::*;

  run_t       run_r;
  logic [1:0] idx_r;
  logic       vld_r;
  logic       last, xfer;
  res_t       cur;

  assign cur  = run_r.slot[idx_r];
  assign last = ((idx_r + 2'd1) == run_r.cnt);
  assign xfer = out_ch.valid && out_ch.ready;
  // Refill when empty or when the last result of the held run goes out.
  assign pop  = !q_stat.empty && (!vld_r || (xfer && last));

  assign out_ch.valid        = vld_r;
  assign out_ch.token_kind   = cur.kind;
  assign out_ch.token_start  = cur.start;
  assign out_ch.token_length = cur.length;
  assign out_ch.field_index  = cur.fidx;
  assign out_ch.error_code   = cur.err;
  assign out_ch.last_of_run  = last;

  always_ff @(posedge clk) begin
    if (pop) run_r <= head_run;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      idx_r <= '0;
    end else if (pop) begin
      vld_r <= 1'b1;
      idx_r <= '0;
    end else if (xfer) begin
      if (last) begin
        vld_r <= 1'b0;
        idx_r <= '0;
      end else begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

endmodule

// File: hdl/http_request_header_tokenizer_unit.sv
// ----------------------------------------------------------------------------
// http_request_header_tokenizer_unit: HTTP/1.1 request header tokenizer
// Splits a request header byte stream into method, URI, version, field
// names and field values, ending each header with a done or error event.
// ----------------------------------------------------------------------------
// The unit takes one header byte per clock on in_ch and reports tokens on
// out_ch, each with its kind, start offset, length, field index and error
// code; last_of_run marks the final result caused by a byte. A byte is
// classified and parsed in the cycle of its transfer, and the up to three
// results it causes enter a four-entry queue as one run. The output stage
// drains one result per cycle while out_ch is ready, so a byte takes one
// input transfer and one output transfer per result (zero to three); most
// bytes cause none. The queue absorbs bursts and short output stalls; the
// input is held back only while all four queue entries are full. After a
// done or error event the unit ignores bytes up to the next byte flagged
// end_of_buffer, which, like every flagged byte, starts a fresh header with
// offsets counted from zero.
// ----------------------------------------------------------------------------
module http_request_header_tokenizer_unit (
  input  logic       clk,
  input  logic       rst_n,
  hrt_in_if.sink     in_ch,
  hrt_out_if.source  out_ch
);
  import hrt_pkg::*;

  // Front end to queue: a run is written only when the byte causes results.
  logic    push, pop;
  run_t    push_run, head_run;
  q_stat_t q_stat;

  hrt_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .q_stat   (q_stat),
    .push     (push),
    .push_run (push_run)
  );

  hrt_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_run (push_run),
    .pop      (pop),
    .head_run (head_run),
    .q_stat   (q_stat)
  );

  // Back end: one result per output transfer.
  hrt_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head_run (head_run),
    .q_stat   (q_stat),
    .pop      (pop),
    .out_ch   (out_ch)
  );

  // A done or error event always closes the run of its byte.
  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.token_kind == K_DONE || out_ch.token_kind == K_ERROR)
    |-> out_ch.last_of_run)
    else $error("end event not last of its run");

  // Only error events carry an error code.
  a_code_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.token_kind != K_ERROR |-> out_ch.error_code == ERR_NONE)
    else $error("error code on a non-error result");

  // The input is held back only while the queue is full.
  a_ready_queue: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> q_stat.full && !q_stat.empty)
    else $error("input stalled with room in the queue");

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the HTTP request header tokenizer
// Streams header bytes into the unit under random source and sink idling.
// Each accepted byte is run through a cycle-free model of the tokenizer, and
// the tokens it must cause are matched in order against what the unit emits.
// ----------------------------------------------------------------------------
module tb_top;
  import hrt_pkg::*;

  localparam int RANDOM_BYTES   = 450;
  localparam int WATCHDOG_LIMIT = 500;
  localparam int TAIL_CYCLES    = 16;

  // One header byte waiting to be sent. When hold is set, the sender waits
  // until every outstanding token has come out before it offers this byte.
  typedef struct packed {
    logic [7:0] data;
    logic       eob;
    logic       hold;
  } hdr_byte_t;

  // One token as the unit must report it.
  typedef struct packed {
    res_t r;
    logic last;
  } token_t;

  logic clk;
  logic rst_n;

  hrt_in_if  in_ch ();
  hrt_out_if out_ch ();

  http_request_header_tokenizer_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #2 clk = ~clk;

  // Stimulus and expectation stores.
  hdr_byte_t   bytes_to_send[$];
  token_t      tokens_due[$];
  logic [7:0]  hdr_text[$];
  int unsigned stim_bytes;
  bit          hold_next;

  // Handshake bookkeeping shared between the rising and falling edge blocks.
  logic        in_taken;
  logic        out_taken;
  int unsigned in_gap;
  int unsigned out_stall;
  bit          in_calm;
  bit          out_calm;
  int unsigned fails;
  int unsigned stall_cycles;

  // Tokenizer model state: parse phase, running byte offset, start of the
  // token being collected and the number of complete header fields.
  logic [3:0]  parse_ph;
  logic [15:0] byte_pos;
  logic [15:0] tok_origin;
  int unsigned field_count;

  // Tokens caused by the byte being modeled, and whether one of them ended
  // the header.
  token_t      byte_run[$];
  bit          run_closed;

  // --------------------------------------------------------------------------
  // Tokenizer model
  // --------------------------------------------------------------------------

  function automatic bit blank_byte(logic [7:0] c);
    return c inside {CH_SP, CH_HT, CH_VT, CH_FF};
  endfunction

  // A byte can cause at most RUN_MAX tokens; anything past that is dropped.
  task automatic add_result(logic [2:0] kind, logic [15:0] start, logic [15:0] len,
                            int unsigned fidx, logic [2:0] err);
    token_t t;
    if (byte_run.size() >= RUN_MAX) return;
    t.r.kind   = kind;
    t.r.start  = start;
    t.r.length = len;
    t.r.fidx   = fidx[4:0];
    t.r.err    = err;
    t.last     = 1'b0;
    byte_run.push_back(t);
    if (kind == K_DONE || kind == K_ERROR) run_closed = 1'b1;
  endtask

  // Token from the saved start up to the current offset; extra = 1 takes in
  // the current byte as well, which happens when the buffer ends on it.
  task automatic add_span(logic [2:0] kind, logic [15:0] extra, int unsigned fidx);
    add_result(kind, tok_origin, byte_pos + extra - tok_origin, fidx, ERR_NONE);
  endtask

  // Done or error: reported at the current offset and the parser halts.
  task automatic close_header(logic [2:0] kind, logic [2:0] err);
    add_result(kind, byte_pos, 16'd0, 0, err);
    parse_ph = PH_HALT;
  endtask

  task automatic reset_parser();
    parse_ph    = PH_METHOD;
    byte_pos    = '0;
    tok_origin  = '0;
    field_count = 0;
  endtask

  // Works out the tokens one accepted byte causes and queues them.
  task automatic tokenize_byte(logic [7:0] c, logic eob);
    bit rl_blank;
    bit halted;
    // A lone LF counts as a blank inside the request line.
    rl_blank   = blank_byte(c) || c == CH_LF;
    halted     = (parse_ph == PH_HALT);
    byte_run.delete();
    run_closed = 1'b0;

    case (parse_ph)
      PH_METHOD: begin
        if (c == CH_CR) close_header(K_ERROR, ERR_REQ_LINE);
        else if (rl_blank) begin
          add_span(K_METHOD, 16'd0, 0);
          parse_ph = PH_URI_SKIP;
        end else if (eob) close_header(K_ERROR, ERR_REQ_LINE);
      end
      PH_URI_SKIP: begin
        // Line break before any URI: an empty URI, then the default version.
        if (c == CH_CR) begin
          add_result(K_URI, byte_pos, 16'd0, 0, ERR_NONE);
          add_result(K_DEFVER, byte_pos, 16'd0, 0, ERR_NONE);
          parse_ph = PH_RL_LF;
        end else if (!rl_blank) begin
          tok_origin = byte_pos;
          parse_ph   = PH_URI;
          if (eob) add_span(K_URI, 16'd1, 0);
        end
      end
      PH_URI: begin
        if (c == CH_CR) begin
          add_span(K_URI, 16'd0, 0);
          add_result(K_DEFVER, byte_pos, 16'd0, 0, ERR_NONE);
          parse_ph = PH_RL_LF;
        end else if (rl_blank) begin
          add_span(K_URI, 16'd0, 0);
          parse_ph = PH_VER_SKIP;
        end else if (eob) add_span(K_URI, 16'd1, 0);
      end
      PH_VER_SKIP: begin
        if (c == CH_CR) begin
          add_result(K_VER, byte_pos, 16'd0, 0, ERR_NONE);
          parse_ph = PH_RL_LF;
        end else if (!rl_blank) begin
          tok_origin = byte_pos;
          parse_ph   = PH_VER;
          if (eob) add_span(K_VER, 16'd1, 0);
        end
      end
      PH_VER: begin
        if (c == CH_CR) begin
          add_span(K_VER, 16'd0, 0);
          parse_ph = PH_RL_LF;
        end else if (rl_blank) begin
          add_span(K_VER, 16'd0, 0);
          parse_ph = PH_VER_TAIL;
        end else if (eob) add_span(K_VER, 16'd1, 0);
      end
      PH_VER_TAIL: begin
        // Only blanks may follow the version on the request line.
        if (c == CH_CR) parse_ph = PH_RL_LF;
        else if (!rl_blank) close_header(K_ERROR, ERR_REQ_LINE);
      end
      PH_RL_LF: begin
        if (c != CH_LF) close_header(K_ERROR, ERR_REQ_LINE);
        else if (eob) close_header(K_DONE, ERR_NONE);
        else parse_ph = PH_NAME_START;
      end
      PH_NAME_START: begin
        if (c == CH_CR) parse_ph = PH_BLANK_LF;
        else if (field_count >= MAX_FIELDS) close_header(K_ERROR, ERR_TOO_MANY);
        else begin
          tok_origin = byte_pos;
          if (c == CH_COLON) begin
            add_span(K_NAME, 16'd0, field_count);
            parse_ph = PH_VAL_SKIP;
          end else if (c == CH_LF) close_header(K_ERROR, ERR_FIELD);
          else parse_ph = PH_NAME;
        end
      end
      PH_NAME: begin
        if (c == CH_COLON) begin
          add_span(K_NAME, 16'd0, field_count);
          parse_ph = PH_VAL_SKIP;
        end else if (c == CH_CR || c == CH_LF) close_header(K_ERROR, ERR_FIELD);
      end
      PH_VAL_SKIP: begin
        if (c == CH_CR || c == CH_LF) close_header(K_ERROR, ERR_FIELD);
        else if (!blank_byte(c)) begin
          tok_origin = byte_pos;
          parse_ph   = PH_VAL;
          if (eob) add_span(K_VALUE, 16'd1, field_count);
        end
      end
      PH_VAL: begin
        if (c == CH_CR) begin
          add_span(K_VALUE, 16'd0, field_count);
          field_count++;
          parse_ph = PH_VAL_LF;
        end else if (eob) add_span(K_VALUE, 16'd1, field_count);
      end
      PH_VAL_LF: begin
        if (c != CH_LF) close_header(K_ERROR, ERR_FIELD);
        else if (eob) close_header(K_DONE, ERR_NONE);
        else parse_ph = PH_NAME_START;
      end
      PH_BLANK_LF: begin
        if (c == CH_LF) close_header(K_DONE, ERR_NONE);
        else close_header(K_ERROR, ERR_FIELD);
      end
      default: parse_ph = PH_HALT;
    endcase

    // A buffer that ends without closing the header is truncated.
    if (eob && !halted && !run_closed) close_header(K_ERROR, ERR_TRUNCATED);
    if (!halted) byte_pos++;
    if (byte_run.size() != 0) byte_run[byte_run.size()-1].last = 1'b1;
    foreach (byte_run[i]) tokens_due.push_back(byte_run[i]);
    // Every flagged byte starts a fresh header.
    if (eob) reset_parser();
  endtask

  // --------------------------------------------------------------------------
  // Stimulus construction
  // --------------------------------------------------------------------------

  // Idle cycles before the next transfer. Each side drifts between a calm
  // mode with no idling at all and a mode with random gaps.
  function automatic int unsigned draw_wait(inout bit calm);
    if ($urandom_range(0, 24) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, 11);
  endfunction

  // Bytes that only pad a halted header or reset the parser are not counted
  // toward the byte budget.
  task automatic push_byte(logic [7:0] c, bit eob, bit counted);
    hdr_byte_t b;
    b.data    = c;
    b.eob     = eob;
    b.hold    = hold_next;
    hold_next = 1'b0;
    bytes_to_send.push_back(b);
    if (counted) stim_bytes++;
  endtask

  // Sends a string; the buffer end flag goes on its last byte if asked.
  task automatic push_text(string s, bit eob_last);
    for (int i = 0; i < s.len(); i++)
      push_byte(s[i], eob_last && i == s.len() - 1, 1'b1);
  endtask

  // Any byte that is neither a blank, a line break byte nor a colon, so that
  // it always continues a token.
  function automatic logic [7:0] token_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c inside {CH_SP, CH_HT, CH_VT, CH_FF, CH_CR, CH_LF, CH_COLON});
    return c;
  endfunction

  task automatic add_token(int unsigned n);
    for (int unsigned i = 0; i < n; i++) hdr_text.push_back(token_char());
  endtask

  // A run of one to three blanks; LF is a blank on the request line only.
  task automatic add_blanks(bit with_lf);
    logic [7:0] pick;
    repeat ($urandom_range(1, 3)) begin
      case ($urandom_range(0, with_lf ? 4 : 3))
        0:       pick = CH_SP;
        1:       pick = CH_HT;
        2:       pick = CH_VT;
        3:       pick = CH_FF;
        default: pick = CH_LF;
      endcase
      hdr_text.push_back(pick);
    end
  endtask

  // Builds one request header with random content and nf field lines, then
  // sends it. Most headers are well formed; some are cut short at a random
  // byte and some have one byte overwritten with a random value.
  task automatic queue_request(int unsigned nf);
    int unsigned flaw;
    int unsigned tok_max;
    int unsigned cut;
    bit          by_eob;
    flaw    = $urandom_range(0, 9);
    tok_max = (nf > 8) ? 1 : 6;
    hdr_text.delete();

    // Request line. The method is sometimes empty (leading blank), the URI
    // sometimes absent, and the version absent, empty or followed by blanks.
    if ($urandom_range(0, 9) != 0) add_token($urandom_range(1, 5));
    add_blanks(1'b1);
    if ($urandom_range(0, 7) != 0) begin
      add_token($urandom_range(1, 8));
      case ($urandom_range(0, 3))
        0: ;
        1: add_blanks(1'b1);
        default: begin
          add_blanks(1'b1);
          add_token($urandom_range(1, 8));
          if ($urandom_range(0, 2) == 0) add_blanks(1'b1);
        end
      endcase
    end
    hdr_text.push_back(CH_CR);
    hdr_text.push_back(CH_LF);

    // Field lines: name, colon, optional blanks, value with an optional inner blank.
    repeat (nf) begin
      if ($urandom_range(0, 14) != 0) add_token($urandom_range(1, tok_max));
      hdr_text.push_back(CH_COLON);
      if ($urandom_range(0, 1) != 0) add_blanks(1'b0);
      add_token($urandom_range(1, tok_max));
      if ($urandom_range(0, 3) == 0) begin
        hdr_text.push_back(CH_SP);
        add_token($urandom_range(1, tok_max));
      end
      hdr_text.push_back(CH_CR);
      hdr_text.push_back(CH_LF);
    end

    // Either the buffer ends on the last LF, or a blank line closes the
    // header and a flagged trailer byte resets the parser afterwards.
    by_eob = 1'($urandom_range(0, 1));
    if (!by_eob) begin
      hdr_text.push_back(CH_CR);
      hdr_text.push_back(CH_LF);
    end

    if (flaw == 7 || flaw == 8) begin
      cut      = $urandom_range(0, hdr_text.size() - 1);
      hdr_text = hdr_text[0:cut];
      by_eob   = 1'b1;
    end else if (flaw == 9) begin
      hdr_text[$urandom_range(0, hdr_text.size() - 1)] = 8'($urandom_range(0, 255));
    end

    foreach (hdr_text[i]) push_byte(hdr_text[i], by_eob && i == hdr_text.size() - 1, 1'b1);
    if (!by_eob) begin
      repeat ($urandom_range(0, 2)) push_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      push_byte(8'($urandom_range(0, 255)), 1'b1, 1'b0);
    end
  endtask

  // Raw noise: random bytes with the buffer end flag set now and then.
  task automatic queue_noise();
    int unsigned n;
    n = $urandom_range(1, 20);
    for (int unsigned i = 0; i < n; i++)
      push_byte(8'($urandom_range(0, 255)), (i == n - 1) || $urandom_range(0, 7) == 0,
                1'b1);
  endtask

  // --------------------------------------------------------------------------
  // Byte driver: changes the input channel on the falling edge. A new byte
  // is offered only when the channel is empty or its byte was transferred at
  // the last rising edge, so valid is assigned once per step.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin : drive_bytes
    hdr_byte_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_gap = 0;
    end else if (!in_ch.valid || in_taken) begin
      if (in_gap != 0) begin
        in_gap--;
        in_ch.valid <= 1'b0;
      end else if (bytes_to_send.size() != 0 &&
                   !(bytes_to_send[0].hold && tokens_due.size() != 0)) begin
        nxt = bytes_to_send.pop_front();
        in_ch.valid         <= 1'b1;
        in_ch.data_byte     <= nxt.data;
        in_ch.end_of_buffer <= nxt.eob;
        in_gap = draw_wait(in_calm);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Token sink: after each transfer it draws a stall and keeps ready low for
  // that many cycles.
  always @(negedge clk) begin : drive_ready
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_stall = 0;
    end else if (out_taken || !out_ch.ready) begin
      if (out_taken) out_stall = draw_wait(out_calm);
      if (out_stall == 0) out_ch.ready <= 1'b1;
      else begin
        out_stall--;
        out_ch.ready <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: on each rising edge, model the byte transferred at that edge
  // first, then check the token transferred at it, so that the outcome does
  // not depend on how fast the unit turns a byte into tokens.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_tokens
    token_t got;
    token_t want;
    if (!rst_n) begin
      in_taken  <= 1'b0;
      out_taken <= 1'b0;
      reset_parser();
    end else begin
      in_taken  <= in_ch.valid && in_ch.ready;
      out_taken <= out_ch.valid && out_ch.ready;
      if (in_ch.valid && in_ch.ready) tokenize_byte(in_ch.data_byte, in_ch.end_of_buffer);
      if (out_ch.valid && out_ch.ready) begin
        got.r.kind   = out_ch.token_kind;
        got.r.start  = out_ch.token_start;
        got.r.length = out_ch.token_length;
        got.r.fidx   = out_ch.field_index;
        got.r.err    = out_ch.error_code;
        got.last     = out_ch.last_of_run;
        if (tokens_due.size() == 0) begin
          if (fails < 10)
            $display("%0t: unexpected token kind %0d start %0d len %0d idx %0d err %0d last %0d",
                     $realtime, got.r.kind, got.r.start, got.r.length, got.r.fidx,
                     got.r.err, got.last);
          fails++;
        end else begin
          want = tokens_due.pop_front();
          if (got !== want) begin
            if (fails < 10) begin
              $write("%0t: token mismatch (expected/actual) kind %0d/%0d start %0d/%0d ",
                     $realtime, want.r.kind, got.r.kind, want.r.start, got.r.start);
              $display("len %0d/%0d idx %0d/%0d err %0d/%0d last %0d/%0d",
                       want.r.length, got.r.length, want.r.fidx, got.r.fidx,
                       want.r.err, got.r.err, want.last, got.last);
            end
            fails++;
          end
        end
      end
    end
  end

  // Watchdog: a correct unit never goes long without a transfer on either
  // side, since draw_wait bounds every gap and stall and the output
  // queue is only four deep.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == WATCHDOG_LIMIT) begin
        $display("http_request_header_tokenizer_unit test failed");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin : run_test
    int unsigned req_n;
    clk                 = 1'b0;
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.data_byte     = '0;
    in_ch.end_of_buffer = 1'b0;
    out_ch.ready        = 1'b0;
    fails               = 0;
    stall_cycles        = 0;
    in_calm             = 1'b0;
    out_calm            = 1'b0;
    hold_next           = 1'b0;
    stim_bytes          = 0;
    reset_parser();

    // Directed headers. Strings use octal escapes for HT, LF, VT, FF and CR.
    // A full header closed by a blank line, then a flagged byte while halted.
    push_text("GET /a HTTP/1.1\015\012Host: x\015\012\015\012", 1'b0);
    push_byte(8'hFF, 1'b1, 1'b0);
    // Leading blank gives an empty method; buffer ends on the request line LF.
    push_text(" u\015\012", 1'b1);
    // CR in the method, and the buffer ending inside the method.
    push_text("\015", 1'b1);
    push_text("AB", 1'b1);
    // Every blank kind, lone LF as a separator, blanks after the version,
    // blanks before a value and inside it.
    push_text("M\011U\012V\013\014\015\012N:\011\014v w\015\012", 1'b1);
    // A non-blank after the version.
    push_text("M U V x", 1'b0);
    push_byte(8'h00, 1'b1, 1'b0);
    // Absent URI, empty field name, and a line break where the value starts.
    push_text("M \015\012:\015", 1'b0);
    push_byte(8'h00, 1'b1, 1'b0);
    // Missing LF after CR, on the request line and on a field line.
    push_text("M U\015Z", 1'b0);
    push_byte(8'h00, 1'b1, 1'b0);
    push_text("M U V\015\012N: v\015Z", 1'b0);
    push_byte(8'h00, 1'b1, 1'b0);
    // LF inside a field name, LF at the start of a field line, broken blank line.
    push_text("M U V\015\012N\012", 1'b0);
    push_byte(8'h00, 1'b1, 1'b0);
    push_text("M U V\015\012\012", 1'b0);
    push_byte(8'h00, 1'b1, 1'b0);
    push_text("M U V\015\012\015Z", 1'b0);
    push_byte(8'h00, 1'b1, 1'b0);
    // Truncations in every token kind, including the three-token case of an
    // absent URI on a buffer that ends on the CR.
    push_text("M U", 1'b1);
    push_text("M U V", 1'b1);
    push_text("M U V\015", 1'b1);
    push_text("M \015", 1'b1);
    push_text("M U ", 1'b1);
    push_text("M U V\015\012N", 1'b1);
    push_text("M U V\015\012N: ", 1'b1);
    push_text("M U V\015\012N: v", 1'b1);
    push_text("M U V\015\012N: v\015\012", 1'b1);
    // Extreme byte values inside tokens.
    push_byte(8'h00, 1'b0, 1'b1);
    push_byte(CH_SP, 1'b0, 1'b1);
    push_byte(8'hFF, 1'b1, 1'b1);

    // Random part, filling the byte budget that the directed headers began.
    // The first random header waits for the directed tokens to drain, and
    // the third one carries more field lines than the limit.
    req_n      = 0;
    hold_next  = 1'b1;
    while (stim_bytes < RANDOM_BYTES) begin
      if (req_n == 2) begin
        hold_next = 1'b1;
        queue_request(MAX_FIELDS + 1);
      end else if ($urandom_range(0, 9) == 0) begin
        queue_noise();
      end else if ($urandom_range(0, 24) == 0) begin
        queue_request($urandom_range(MAX_FIELDS - 2, MAX_FIELDS + 2));
      end else begin
        queue_request($urandom_range(0, 4));
      end
      req_n++;
    end

    repeat (3) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Wait for the last byte transfer, then for the last token, then allow
    // the output queue time to show any token that should not be there.
    while (bytes_to_send.size() != 0 || in_ch.valid) @(negedge clk);
    while (tokens_due.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (fails == 0) begin
      $display("http_request_header_tokenizer_unit test passed");
    end else begin
      $display("http_request_header_tokenizer_unit test failed");
    end
    $finish;
  end

endmodule
